// ===== hw/rtl/balsm_pkg.sv =====
// shared widths and command codes of the byte-addressed load/store memory
`default_nettype none
package balsm_pkg;

	localparam int unsigned ADDR_BITS_DEF = 16;
	localparam int unsigned ADDR_W        = 16;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned CMD_W         = 3;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned LANES         = 4;
	localparam int unsigned LANE_W        = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ST_WORD  = 3'd0,
		CMD_ST_HALF  = 3'd1,
		CMD_ST_BYTE  = 3'd2,
		CMD_LD_WORD  = 3'd3,
		CMD_LD_HALF  = 3'd4,
		CMD_LD_BYTE  = 3'd5,
		CMD_LD_BYTEU = 3'd6,
		CMD_LD_HALFU = 3'd7
	} cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/balsm_req_if.sv =====
// request channel: command, address and store data
`default_nettype none
interface balsm_req_if;
	logic                             valid;
	logic                             ready;
	logic [balsm_pkg::CMD_W-1:0]      command;
	logic [balsm_pkg::ADDR_W-1:0]     address;
	logic [balsm_pkg::DATA_W-1:0]     store_data;

	modport source (output valid, command, address, store_data, input ready);
	modport sink (input valid, command, address, store_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/balsm_rsp_if.sv =====
// response channel: load data
`default_nettype none
interface balsm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [balsm_pkg::DATA_W-1:0]  load_data;

	modport source (output valid, load_data, input ready);
	modport sink (input valid, load_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/balsm_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module balsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/byte_addressed_load_store_memory_unit.sv =====
// top level: byte-addressed little-endian load/store data memory in four byte banks
//
//  channel | dir | fields                           | per word
//  req     | in  | command, address, store_data     | one load or store
//  rsp     | out | load_data                        | one per load, none per store
//
// one word per cycle unless rsp stalls or the clearing pass runs; a load result passes bank read, then output reg
// four byte-wide banks of 2^(ADDR_BITS-2) rows each, one row per bank per access, cover any unaligned word
// after reset a clearing pass zeroes every row of the banks; req.ready stays low
// a stalled rsp holds the output reg and the bank read stage; req.ready drops when both are full
`default_nettype none
module byte_addressed_load_store_memory_unit #(
	parameter int unsigned ADDR_BITS = balsm_pkg::ADDR_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	balsm_req_if.sink   req,
	balsm_rsp_if.source rsp
);

	localparam int unsigned ROW_BITS = ADDR_BITS - balsm_pkg::LANE_W;
	localparam int unsigned DEPTH    = 2 ** ROW_BITS;
	localparam int unsigned NL       = balsm_pkg::LANES;
	localparam int unsigned LW       = balsm_pkg::LANE_W;
	localparam int unsigned BW       = balsm_pkg::BYTE_W;
	localparam int unsigned DW       = balsm_pkg::DATA_W;

	logic                 clr_busy_q;
	logic [ROW_BITS-1:0]  clr_row_q;

	logic                 s1_valid_q;
	balsm_pkg::cmd_t      cmd_s1;
	logic [LW-1:0]        ofs_s1;

	logic                 out_valid_q;
	logic [DW-1:0]        load_data_q;

	logic [ADDR_BITS-1:0] addr_eff;
	logic [ROW_BITS-1:0]  row_base;
	logic [LW-1:0]        ofs;
	balsm_pkg::cmd_t      cmd;
	logic                 is_load;
	logic                 acc;
	logic                 s1_adv;

	logic [ROW_BITS-1:0]  bank_row   [NL];
	logic [LW-1:0]        bank_lane  [NL];
	logic                 bank_we    [NL];
	logic [ROW_BITS-1:0]  bank_waddr [NL];
	logic [BW-1:0]        bank_wdata [NL];
	logic [BW-1:0]        bank_rdata [NL];

	logic [DW-1:0]        raw;
	logic [DW-1:0]        ext;

	assign addr_eff = ADDR_BITS'(req.address);
	assign row_base = addr_eff[ADDR_BITS-1:LW];
	assign ofs      = addr_eff[LW-1:0];
	assign cmd      = balsm_pkg::cmd_t'(req.command);
	assign is_load  = !(cmd == balsm_pkg::CMD_ST_WORD || cmd == balsm_pkg::CMD_ST_HALF
		|| cmd == balsm_pkg::CMD_ST_BYTE);

	assign s1_adv    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign acc       = req.valid && req.ready;

	// per-bank lane and row, wrapping at the top
	always_comb begin
		for (int b = 0; b < NL; b++) begin
			bank_lane[b]  = LW'(b) - ofs;
			bank_row[b]   = row_base + ROW_BITS'(LW'(b) < ofs);
			bank_we[b]    = clr_busy_q || (acc && (cmd == balsm_pkg::CMD_ST_WORD
				|| (cmd == balsm_pkg::CMD_ST_HALF && bank_lane[b] <= LW'(1))
				|| (cmd == balsm_pkg::CMD_ST_BYTE && bank_lane[b] == LW'(0))));
			bank_waddr[b] = clr_busy_q ? clr_row_q : bank_row[b];
			bank_wdata[b] = clr_busy_q ? '0 : req.store_data[BW*bank_lane[b] +: BW];
		end
	end

	for (genvar g = 0; g < NL; g++) begin : g_bank
		balsm_ram #(
			.WIDTH (BW),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[g]),
			.waddr (bank_waddr[g]),
			.wdata (bank_wdata[g]),
			.re    (acc && is_load),
			.raddr (bank_row[g]),
			.rdata (bank_rdata[g])
		);
	end

	// little-endian assembly and extension
	always_comb begin
		for (int i = 0; i < NL; i++) begin
			raw[BW*i +: BW] = bank_rdata[ofs_s1 + LW'(i)];
		end
		case (cmd_s1)
			balsm_pkg::CMD_LD_HALF:  ext = {{16{raw[15]}}, raw[15:0]};
			balsm_pkg::CMD_LD_BYTE:  ext = {{24{raw[7]}}, raw[7:0]};
			balsm_pkg::CMD_LD_BYTEU: ext = {24'd0, raw[7:0]};
			balsm_pkg::CMD_LD_HALFU: ext = {16'd0, raw[15:0]};
			default:                 ext = raw;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + ROW_BITS'(1);
			if (clr_row_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= is_load;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_load) begin
			cmd_s1 <= cmd;
			ofs_s1 <= ofs;
		end
		if (s1_adv) begin
			load_data_q <= ext;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.load_data = load_data_q;

`ifndef SYNTHESIS
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !req.ready)
		else $error("word accepted during clearing pass");

	a_load_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_load) |=> s1_valid_q)
		else $error("accepted load missing from read stage");

	a_store_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !is_load) |=> !s1_valid_q)
		else $error("store produced a read stage entry");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(cmd_s1) && $stable(ofs_s1)))
		else $error("stalled read stage lost its word");
`endif

endmodule
`default_nettype wire

// ===== sim/balsm_checker.sv =====
// checker for the load/store memory: tracks a byte image and compares every load word
`default_nettype none
module balsm_checker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	balsm_req_if        req,
	balsm_rsp_if        rsp,
	output int unsigned fails,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import balsm_pkg::*;

	localparam int unsigned SPAN = 1 << ADDR_BITS_DEF;

	logic [BYTE_W-1:0] mem_image [SPAN];
	logic [DATA_W-1:0] load_expect [$];
	logic [DATA_W-1:0] word;
	int unsigned       errors = 0;

	function automatic logic [DATA_W-1:0] fetch_bytes(logic [ADDR_W-1:0] addr,
			int unsigned count);
		logic [DATA_W-1:0] acc;
		int unsigned       idx;
		acc = '0;
		for (int unsigned i = 0; i < count; i++) begin
			idx = (int'(addr) + i) % SPAN;
			acc |= DATA_W'(mem_image[idx]) << (BYTE_W * i);
		end
		return acc;
	endfunction

	task automatic deposit_bytes(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
			int unsigned count);
		int unsigned idx;
		for (int unsigned i = 0; i < count; i++) begin
			idx = (int'(addr) + i) % SPAN;
			mem_image[idx] = data[BYTE_W*i +: BYTE_W];
		end
	endtask

	task automatic report_error(string what, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want);
		$display("%0t load_data %s: got %h want %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_expect.delete();
			foreach (mem_image[i]) mem_image[i] = '0;
			pending <= 0;
			fails <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (load_expect.size() == 0) begin
					report_error("with no load outstanding", rsp.load_data, '0);
				end else begin
					word = load_expect.pop_front();
					if (rsp.load_data !== word) report_error("differs", rsp.load_data, word);
				end
			end
			if (req.valid && req.ready) begin
				case (cmd_t'(req.command))
					CMD_ST_WORD: deposit_bytes(req.address, req.store_data, 4);
					CMD_ST_HALF: deposit_bytes(req.address, req.store_data, 2);
					CMD_ST_BYTE: deposit_bytes(req.address, req.store_data, 1);
					CMD_LD_WORD: load_expect.push_back(fetch_bytes(req.address, 4));
					CMD_LD_HALF: begin
						word = fetch_bytes(req.address, 2);
						load_expect.push_back({{16{word[15]}}, word[15:0]});
					end
					CMD_LD_BYTE: begin
						word = fetch_bytes(req.address, 1);
						load_expect.push_back({{24{word[7]}}, word[7:0]});
					end
					CMD_LD_BYTEU: load_expect.push_back(fetch_bytes(req.address, 1));
					default: load_expect.push_back(fetch_bytes(req.address, 2));
				endcase
			end
			pending <= load_expect.size();
			fails <= errors;
		end
	end
endmodule
`default_nettype wire

// ===== sim/byte_addressed_load_store_memory_unit_tb.sv =====
// testbench top: clock, reset, load/store word stimulus, response stalls and verdict
`default_nettype none
module byte_addressed_load_store_memory_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import balsm_pkg::*;

	logic        clk;
	logic        arst_n;
	bit          calm;
	int unsigned hold;
	int unsigned fails;
	int unsigned pending;

	balsm_req_if req_ch ();
	balsm_rsp_if rsp_ch ();

	byte_addressed_load_store_memory_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	balsm_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("byte_addressed_load_store_memory_unit: mismatch");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold = 0;
		end else if (hold > 0) begin
			rsp_ch.ready <= 1'b0;
			hold--;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!calm) hold = idle_len();
		end
	end

	// returns at the edge where the word is taken
	task automatic issue(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		int unsigned gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.address <= addr;
		req_ch.store_data <= data;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain_pending();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_random(int unsigned total);
		int unsigned       sent;
		int unsigned       n;
		int unsigned       next_drain;
		logic [ADDR_W-1:0] base;
		sent = 0;
		next_drain = 250;
		while (sent < total) begin
			calm = ((sent / 100) % 4) == 3;
			if (sent >= next_drain) begin
				drain_pending();
				next_drain += 250;
			end
			if ($urandom_range(0, 3) == 0) begin
				issue(cmd_t'(3'($urandom_range(0, 7))), ADDR_W'($urandom), $urandom);
				sent++;
			end else begin
				case ($urandom_range(0, 3))
					0: base = ADDR_W'($urandom);
					1: base = 16'hFFFC + ADDR_W'($urandom_range(0, 3));
					2: base = ADDR_W'($urandom_range(0, 7));
					default: base = 16'h4000 + ADDR_W'($urandom_range(0, 31));
				endcase
				n = $urandom_range(1, 3);
				repeat (n) begin
					issue(cmd_t'(3'($urandom_range(0, 2))),
						base + ADDR_W'($urandom_range(0, 3)), $urandom);
					sent++;
				end
				n = $urandom_range(1, 4);
				repeat (n) begin
					issue(cmd_t'(3'($urandom_range(3, 7))),
						base + ADDR_W'($urandom_range(0, 3)), $urandom);
					sent++;
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ST_WORD;
		req_ch.address = '0;
		req_ch.store_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// never written reads zero
		issue(CMD_LD_WORD, 16'h1234, 32'h0000_0000);
		// word wrapping past the top
		issue(CMD_ST_WORD, 16'hFFFE, 32'h80FF_7F01);
		issue(CMD_LD_WORD, 16'hFFFE, 32'hFFFF_FFFF);
		issue(CMD_LD_HALF, 16'hFFFF, 32'h0000_0000);
		issue(CMD_LD_HALFU, 16'hFFFF, 32'h0000_0000);
		issue(CMD_LD_BYTE, 16'h0000, 32'h0000_0000);
		issue(CMD_LD_BYTEU, 16'h0000, 32'h0000_0000);
		issue(CMD_LD_BYTE, 16'hFFFF, 32'h0000_0000);
		issue(CMD_LD_HALF, 16'h0000, 32'h0000_0000);
		issue(CMD_ST_HALF, 16'h0000, 32'hFFFF_1234);
		issue(CMD_ST_BYTE, 16'hFFFF, 32'hFFFF_FF80);
		issue(CMD_LD_WORD, 16'hFFFD, 32'h0000_0000);
		issue(CMD_ST_WORD, 16'h0000, 32'hFFFF_FFFF);
		issue(CMD_LD_WORD, 16'h0000, 32'h0000_0000);
		issue(CMD_ST_WORD, 16'h7FFF, 32'h0000_0000);
		issue(CMD_LD_WORD, 16'h7FFE, 32'h0000_0000);
		issue(CMD_ST_BYTE, 16'h8000, 32'h0000_00FF);
		issue(CMD_LD_HALF, 16'h7FFF, 32'h0000_0000);
		issue(CMD_LD_HALFU, 16'h8000, 32'h0000_0000);
		issue(CMD_LD_BYTEU, 16'hFFFF, 32'h0000_0000);
		issue(CMD_ST_HALF, 16'h5555, 32'hAAAA_8001);
		issue(CMD_LD_HALFU, 16'h5555, 32'h0000_0000);
		issue(CMD_LD_HALF, 16'h5554, 32'h0000_0000);
		issue(CMD_LD_BYTE, 16'h5556, 32'h0000_0000);
		drain_pending();

		run_random(850);
		drain_pending();
		repeat (8) @(posedge clk);

		if (fails == 0 && pending == 0) begin
			$display("byte_addressed_load_store_memory_unit: match");
		end else begin
			$display("byte_addressed_load_store_memory_unit: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
